// File: design/threshold_centroid_macros.svh
// Assertion macros used by threshold_centroid.sv to check its own logic.
`ifndef THRESHOLD_CENTROID_MACROS_SVH
`define THRESHOLD_CENTROID_MACROS_SVH

`ifndef SYNTHESIS

`define TC_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("implication check failed");

`define TC_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("next cycle check failed");

`else

`define TC_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define TC_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// File: design/tc_pkg.sv
`default_nettype none

package tc_pkg;

  localparam int PIXEL_W   = 8;
  localparam int THRESH_W  = 9;
  localparam int SIZE_W    = 11;
  localparam int CENTER_W  = 18;
  localparam int HIT_W     = 21;
  localparam int REG_IDX_W = 2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(128);
  localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(1024);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_LOAD,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic accept_pixel;
    logic start_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
  } status_t;

endpackage

`default_nettype wire

// File: design/threshold_centroid.sv
// Pixels are taken one per cycle; only the last pixel of a frame can wait.
// The result is computed after the last pixel of a frame by two restoring
// dividers that produce one quotient bit per cycle. Pixels of the next
// frame are taken meanwhile; its last pixel waits until the result is taken.
// Reset (rst, synchronous): position, sums and hit count clear; threshold 128.
`default_nettype none

`include "threshold_centroid_macros.svh"

module threshold_centroid
  import tc_pkg::*;
#(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 write_enable,
  input  wire logic [REG_IDX_W-1:0] write_index,
  input  wire logic [SIZE_W-1:0]    write_data,
  input  wire logic                 pixel_valid,
  output logic                      pixel_stall,
  input  wire logic [PIXEL_W-1:0]   pixel,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic      [CENTER_W-1:0]  center_x,
  output logic      [CENTER_W-1:0]  center_y,
  output logic      [HIT_W-1:0]     hit_count,
  output logic                      found
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int SUM_W = CW + RW + MW;
  localparam int DW    = SUM_W + FRACTION_BITS;

  cmd_t    cmd;
  status_t status;

  tc_ctrl #(
    .DIV_STEPS(DW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status      (status),
    .cmd         (cmd)
  );

  tc_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .write_index (write_index),
    .write_data  (write_data),
    .pixel       (pixel),
    .cmd         (cmd),
    .status      (status),
    .center_x    (center_x),
    .center_y    (center_y),
    .hit_count   (hit_count),
    .found       (found)
  );

  `TC_ASSERT_NEXT(a_div_follows_start, clk, rst, cmd.start_div, cmd.div_step)
  `TC_ASSERT_IMPLIES(a_no_step_while_held, clk, rst, result_valid, !cmd.div_step)
  `TC_ASSERT_IMPLIES(a_empty_zero, clk, rst, result_valid && !found, (center_x | center_y) == '0)
  `TC_ASSERT_IMPLIES(a_found_count, clk, rst, result_valid, found == (hit_count != '0))
  `TC_ASSERT_IMPLIES(a_frame_end_waits, clk, rst, status.frame_end && result_valid, pixel_stall)

endmodule

`default_nettype wire

// File: design/tc_div.sv
`default_nettype none

module tc_div
  import tc_pkg::*;
#(
  parameter int DIVIDEND_W = 38
) (
  input  wire logic                  clk,
  input  wire logic                  load,
  input  wire logic                  step,
  input  wire logic [DIVIDEND_W-1:0] dividend_in,
  input  wire logic [HIT_W-1:0]      divisor_in,
  output logic      [CENTER_W-1:0]   quotient
);

  logic [DIVIDEND_W-1:0] dividend;
  logic [HIT_W-1:0]      divisor;
  logic [HIT_W-1:0]      remainder;
  logic [HIT_W:0]        trial;
  logic [HIT_W:0]        diff;
  logic                  fits;

  // Restoring division, one quotient bit per step. Only the low quotient
  // bits are kept, which is the masked result.
  assign trial = {remainder, dividend[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (load) begin
      dividend  <= dividend_in;
      divisor   <= divisor_in;
      remainder <= '0;
      quotient  <= '0;
    end else if (step) begin
      dividend  <= dividend << 1;
      remainder <= fits ? diff[HIT_W-1:0] : trial[HIT_W-1:0];
      quotient  <= {quotient[CENTER_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: design/tc_datapath.sv
`default_nettype none

module tc_datapath
  import tc_pkg::*;
#(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int FRACTION_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 write_enable,
  input  wire logic [REG_IDX_W-1:0] write_index,
  input  wire logic [SIZE_W-1:0]    write_data,
  input  wire logic [PIXEL_W-1:0]   pixel,
  input  wire cmd_t                 cmd,
  output status_t                   status,
  output logic      [CENTER_W-1:0]  center_x,
  output logic      [CENTER_W-1:0]  center_y,
  output logic      [HIT_W-1:0]     hit_count,
  output logic                      found
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int SUM_W = CW + RW + MW;
  localparam int DW    = SUM_W + FRACTION_BITS;
  localparam int XW    = ((SIZE_W > MW) ? SIZE_W : MW) + 1;

  logic [THRESH_W-1:0] threshold;
  logic [SIZE_W-1:0]   frame_width;
  logic [SIZE_W-1:0]   frame_height;

  logic [CW-1:0]    column;
  logic [RW-1:0]    row;
  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [HIT_W-1:0] hits;

  logic [XW-1:0]    width_ext;
  logic [XW-1:0]    height_ext;
  logic [XW-1:0]    column_last;
  logic [XW-1:0]    row_last;
  logic             row_end;
  logic             hit;
  logic [SUM_W-1:0] sum_x_add;
  logic [SUM_W-1:0] sum_y_add;
  logic [HIT_W-1:0] hits_add;
  logic [HIT_W-1:0] divisor;
  logic [CENTER_W-1:0] quot_x;
  logic [CENTER_W-1:0] quot_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESH_RESET;
      frame_width  <= SIZE_RESET;
      frame_height <= SIZE_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_THRESHOLD:    threshold    <= write_data[THRESH_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= write_data;
        REG_FRAME_HEIGHT: frame_height <= write_data;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one and a size above the maximum acts as the maximum.
  assign width_ext  = XW'(frame_width);
  assign height_ext = XW'(frame_height);

  always_comb begin
    if (width_ext == '0) begin
      column_last = '0;
    end else if (width_ext > XW'(MAX_WIDTH)) begin
      column_last = XW'(MAX_WIDTH - 1);
    end else begin
      column_last = width_ext - XW'(1);
    end
    if (height_ext == '0) begin
      row_last = '0;
    end else if (height_ext > XW'(MAX_HEIGHT)) begin
      row_last = XW'(MAX_HEIGHT - 1);
    end else begin
      row_last = height_ext - XW'(1);
    end
  end

  assign row_end          = XW'(column) >= column_last;
  assign status.frame_end = row_end && (XW'(row) >= row_last);

  assign hit       = {1'b0, pixel} >= threshold;
  assign sum_x_add = sum_x + (hit ? SUM_W'(column) : '0);
  assign sum_y_add = sum_y + (hit ? SUM_W'(row) : '0);
  assign hits_add  = hits + HIT_W'(hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      hits   <= '0;
    end else if (cmd.accept_pixel) begin
      if (status.frame_end) begin
        column <= '0;
        row    <= '0;
        sum_x  <= '0;
        sum_y  <= '0;
        hits   <= '0;
      end else begin
        sum_x <= sum_x_add;
        sum_y <= sum_y_add;
        hits  <= hits_add;
        if (row_end) begin
          column <= '0;
          row    <= row + RW'(1);
        end else begin
          column <= column + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      divisor <= hits_add;
    end
  end

  tc_div #(
    .DIVIDEND_W(DW)
  ) u_div_x (
    .clk        (clk),
    .load       (cmd.start_div),
    .step       (cmd.div_step),
    .dividend_in(DW'(sum_x_add) << FRACTION_BITS),
    .divisor_in (hits_add),
    .quotient   (quot_x)
  );

  tc_div #(
    .DIVIDEND_W(DW)
  ) u_div_y (
    .clk        (clk),
    .load       (cmd.start_div),
    .step       (cmd.div_step),
    .dividend_in(DW'(sum_y_add) << FRACTION_BITS),
    .divisor_in (hits_add),
    .quotient   (quot_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit_count <= divisor;
      found     <= divisor != '0;
      center_x  <= (divisor != '0) ? quot_x : '0;
      center_y  <= (divisor != '0) ? quot_y : '0;
    end
  end

endmodule

`default_nettype wire

// File: design/tc_ctrl.sv
`default_nettype none

module tc_ctrl
  import tc_pkg::*;
#(
  parameter int DIV_STEPS = 38
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pixel_valid,
  output logic         pixel_stall,
  output logic         result_valid,
  input  wire logic    result_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             last_step;

  assign last_step = count == CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIVIDE) begin
        count <= count + CNT_W'(1);
      end else begin
        count <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pixel_valid && status.frame_end) begin
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (last_step) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (!result_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Pixels inside a frame flow at any time; the last beat of a frame waits
  // until the divider and the result register are free.
  always_comb begin
    pixel_stall      = status.frame_end && (state != S_IDLE);
    result_valid     = state == S_HOLD;
    cmd.accept_pixel = pixel_valid && !pixel_stall;
    cmd.start_div    = pixel_valid && !pixel_stall && status.frame_end;
    cmd.div_step     = state == S_DIVIDE;
    cmd.load_out     = state == S_LOAD;
  end

endmodule

`default_nettype wire
